FILE: src/lus_pkg.sv
package lus_pkg;

    // control bits that travel with each request through the pipeline
    typedef struct packed {
        logic valid;
        logic singular;
    } lus_tag_t;

endpackage

FILE: src/lu_solve_3x3.sv
// 3x3 Doolittle LU solve, fixed point, fully pipelined.
// Pipeline depth is set by five chained bit-per-stage dividers (l21/l31, l32, x3, x2, x1)
// plus multiply/subtract stages.
// Throughput: one request per cycle; a stall on the output freezes the whole pipe.
// Reset clears all valid bits asynchronously; data registers are not reset.
module lu_solve_3x3 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] a11,
    input  logic signed [DATA_WIDTH-1:0] a12,
    input  logic signed [DATA_WIDTH-1:0] a13,
    input  logic signed [DATA_WIDTH-1:0] a21,
    input  logic signed [DATA_WIDTH-1:0] a22,
    input  logic signed [DATA_WIDTH-1:0] a23,
    input  logic signed [DATA_WIDTH-1:0] a31,
    input  logic signed [DATA_WIDTH-1:0] a32,
    input  logic signed [DATA_WIDTH-1:0] a33,
    input  logic signed [DATA_WIDTH-1:0] b1,
    input  logic signed [DATA_WIDTH-1:0] b2,
    input  logic signed [DATA_WIDTH-1:0] b3,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] x1,
    output logic signed [DATA_WIDTH-1:0] x2,
    output logic signed [DATA_WIDTH-1:0] x3,
    output logic                         singular
);
    import lus_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;

    typedef logic signed [W-1:0] word_t;

    function automatic word_t fx_sub(word_t a, word_t b);
        logic signed [W:0] d;
        d = {a[W-1], a} - {b[W-1], b};
        if (d[W] != d[W-1])
            return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return d[W-1:0];
    endfunction

    function automatic word_t fx_mul(word_t a, word_t b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] p;
        logic [2*W-1:0] lim;
        logic           neg;
        ma  = a[W-1] ? (~a + W'(1)) : a;
        mb  = b[W-1] ? (~b + W'(1)) : b;
        neg = a[W-1] ^ b[W-1];
        p   = ({{W{1'b0}}, ma} * {{W{1'b0}}, mb}) >> F;
        lim = {{(W+1){1'b0}}, {(W-1){1'b1}}} + (2*W)'(neg);
        if (p > lim)
            p = lim;
        return neg ? (~p[W-1:0] + W'(1)) : p[W-1:0];
    endfunction

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // input stage
    lus_tag_t t0_reg;
    word_t a11_reg, a12_reg, a13_reg, a21_reg, a22_reg, a23_reg;
    word_t a31_reg, a32_reg, a33_reg, b1_reg, b2_reg, b3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t0_reg <= '0;
        else if (en)
            t0_reg <= '{valid: in_valid, singular: (a11 == '0)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a11_reg <= a11; a12_reg <= a12; a13_reg <= a13;
            a21_reg <= a21; a22_reg <= a22; a23_reg <= a23;
            a31_reg <= a31; a32_reg <= a32; a33_reg <= a33;
            b1_reg  <= b1;  b2_reg  <= b2;  b3_reg  <= b3;
        end
    end

    // l21 = a21 / a11, l31 = a31 / a11
    lus_tag_t ta1, ta2;
    word_t    l21, l31;
    logic [4*W-1:0] sa1;
    logic [6*W-1:0] sa2;

    lus_div #(.W(W), .F(F), .SIDE_W(4*W)) u_div_l21 (
        .clk(clk), .rst_n(rst_n), .en(en), .tag_in(t0_reg),
        .num(a21_reg), .den(a11_reg),
        .side_in({a12_reg, a13_reg, a22_reg, a23_reg}),
        .tag_out(ta1), .quo(l21), .side_out(sa1)
    );

    lus_div #(.W(W), .F(F), .SIDE_W(6*W)) u_div_l31 (
        .clk(clk), .rst_n(rst_n), .en(en), .tag_in(t0_reg),
        .num(a31_reg), .den(a11_reg),
        .side_in({a32_reg, a33_reg, b1_reg, b2_reg, b3_reg, a11_reg}),
        .tag_out(ta2), .quo(l31), .side_out(sa2)
    );

    // products with l21, l31
    lus_tag_t t1_reg;
    word_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    word_t c12_1_reg, c13_1_reg, c22_1_reg, c23_1_reg, c32_1_reg, c33_1_reg;
    word_t b1_1_reg, b2_1_reg, b3_1_reg, a11_1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t1_reg <= '0;
        else if (en)
            t1_reg <= '{valid: ta1.valid & ta2.valid,
                        singular: ta1.singular | ta2.singular};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= fx_mul(l21, sa1[4*W-1:3*W]);
            p2_reg <= fx_mul(l21, sa1[3*W-1:2*W]);
            p3_reg <= fx_mul(l31, sa1[4*W-1:3*W]);
            p4_reg <= fx_mul(l31, sa1[3*W-1:2*W]);
            p5_reg <= fx_mul(l21, sa2[4*W-1:3*W]);
            p6_reg <= fx_mul(l31, sa2[4*W-1:3*W]);
            c12_1_reg <= sa1[4*W-1:3*W];
            c13_1_reg <= sa1[3*W-1:2*W];
            c22_1_reg <= sa1[2*W-1:W];
            c23_1_reg <= sa1[W-1:0];
            c32_1_reg <= sa2[6*W-1:5*W];
            c33_1_reg <= sa2[5*W-1:4*W];
            b1_1_reg  <= sa2[4*W-1:3*W];
            b2_1_reg  <= sa2[3*W-1:2*W];
            b3_1_reg  <= sa2[2*W-1:W];
            a11_1_reg <= sa2[W-1:0];
        end
    end

    // second row of U, partial third row, y2
    lus_tag_t t2_reg;
    word_t u22_reg, u23_reg, t32_reg, t33_reg, y2_reg, t3_reg;
    word_t c12_2_reg, c13_2_reg, b1_2_reg, a11_2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t2_reg <= '0;
        else if (en)
            t2_reg <= t1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u22_reg   <= fx_sub(c22_1_reg, p1_reg);
            u23_reg   <= fx_sub(c23_1_reg, p2_reg);
            t32_reg   <= fx_sub(c32_1_reg, p3_reg);
            t33_reg   <= fx_sub(c33_1_reg, p4_reg);
            y2_reg    <= fx_sub(b2_1_reg, p5_reg);
            t3_reg    <= fx_sub(b3_1_reg, p6_reg);
            c12_2_reg <= c12_1_reg;
            c13_2_reg <= c13_1_reg;
            b1_2_reg  <= b1_1_reg;
            a11_2_reg <= a11_1_reg;
        end
    end

    // l32 = t32 / u22
    lus_tag_t tb_in, tb;
    word_t    l32;
    logic [9*W-1:0] sb;

    always_comb
    begin
        tb_in = t2_reg;
        tb_in.singular = t2_reg.singular | (u22_reg == '0);
    end

    lus_div #(.W(W), .F(F), .SIDE_W(9*W)) u_div_l32 (
        .clk(clk), .rst_n(rst_n), .en(en), .tag_in(tb_in),
        .num(t32_reg), .den(u22_reg),
        .side_in({u22_reg, u23_reg, t33_reg, y2_reg, t3_reg,
                  c12_2_reg, c13_2_reg, b1_2_reg, a11_2_reg}),
        .tag_out(tb), .quo(l32), .side_out(sb)
    );

    lus_tag_t t3s_reg;
    word_t q1_reg, q2_reg;
    word_t u22_3_reg, u23_3_reg, t33_3_reg, y2_3_reg, t3_3_reg;
    word_t c12_3_reg, c13_3_reg, b1_3_reg, a11_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t3s_reg <= '0;
        else if (en)
            t3s_reg <= tb;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= fx_mul(l32, sb[8*W-1:7*W]);
            q2_reg    <= fx_mul(l32, sb[6*W-1:5*W]);
            u22_3_reg <= sb[9*W-1:8*W];
            u23_3_reg <= sb[8*W-1:7*W];
            t33_3_reg <= sb[7*W-1:6*W];
            y2_3_reg  <= sb[6*W-1:5*W];
            t3_3_reg  <= sb[5*W-1:4*W];
            c12_3_reg <= sb[4*W-1:3*W];
            c13_3_reg <= sb[3*W-1:2*W];
            b1_3_reg  <= sb[2*W-1:W];
            a11_3_reg <= sb[W-1:0];
        end
    end

    // u33, y3
    lus_tag_t t4_reg;
    word_t u33_reg, y3_reg;
    word_t u22_4_reg, u23_4_reg, y2_4_reg, c12_4_reg, c13_4_reg, b1_4_reg, a11_4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t4_reg <= '0;
        else if (en)
            t4_reg <= t3s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u33_reg   <= fx_sub(t33_3_reg, q1_reg);
            y3_reg    <= fx_sub(t3_3_reg, q2_reg);
            u22_4_reg <= u22_3_reg;
            u23_4_reg <= u23_3_reg;
            y2_4_reg  <= y2_3_reg;
            c12_4_reg <= c12_3_reg;
            c13_4_reg <= c13_3_reg;
            b1_4_reg  <= b1_3_reg;
            a11_4_reg <= a11_3_reg;
        end
    end

    // x3 = y3 / u33
    lus_tag_t tc_in, tc;
    word_t    x3q;
    logic [7*W-1:0] sc;

    always_comb
    begin
        tc_in = t4_reg;
        tc_in.singular = t4_reg.singular | (u33_reg == '0);
    end

    lus_div #(.W(W), .F(F), .SIDE_W(7*W)) u_div_x3 (
        .clk(clk), .rst_n(rst_n), .en(en), .tag_in(tc_in),
        .num(y3_reg), .den(u33_reg),
        .side_in({u22_4_reg, u23_4_reg, y2_4_reg, c12_4_reg, c13_4_reg,
                  b1_4_reg, a11_4_reg}),
        .tag_out(tc), .quo(x3q), .side_out(sc)
    );

    lus_tag_t t5_reg;
    word_t r_reg, s_reg, x3_5_reg;
    word_t u22_5_reg, y2_5_reg, c12_5_reg, b1_5_reg, a11_5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t5_reg <= '0;
        else if (en)
            t5_reg <= tc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= fx_mul(sc[6*W-1:5*W], x3q);
            s_reg     <= fx_mul(sc[3*W-1:2*W], x3q);
            x3_5_reg  <= x3q;
            u22_5_reg <= sc[7*W-1:6*W];
            y2_5_reg  <= sc[5*W-1:4*W];
            c12_5_reg <= sc[4*W-1:3*W];
            b1_5_reg  <= sc[2*W-1:W];
            a11_5_reg <= sc[W-1:0];
        end
    end

    lus_tag_t t6_reg;
    word_t n2_reg, s_6_reg, x3_6_reg, u22_6_reg, c12_6_reg, b1_6_reg, a11_6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t6_reg <= '0;
        else if (en)
            t6_reg <= t5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= fx_sub(y2_5_reg, r_reg);
            s_6_reg   <= s_reg;
            x3_6_reg  <= x3_5_reg;
            u22_6_reg <= u22_5_reg;
            c12_6_reg <= c12_5_reg;
            b1_6_reg  <= b1_5_reg;
            a11_6_reg <= a11_5_reg;
        end
    end

    // x2 = n2 / u22
    lus_tag_t td;
    word_t    x2q;
    logic [5*W-1:0] sd;

    lus_div #(.W(W), .F(F), .SIDE_W(5*W)) u_div_x2 (
        .clk(clk), .rst_n(rst_n), .en(en), .tag_in(t6_reg),
        .num(n2_reg), .den(u22_6_reg),
        .side_in({s_6_reg, x3_6_reg, c12_6_reg, b1_6_reg, a11_6_reg}),
        .tag_out(td), .quo(x2q), .side_out(sd)
    );

    lus_tag_t t7_reg;
    word_t w_reg, s_7_reg, x3_7_reg, x2_7_reg, b1_7_reg, a11_7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t7_reg <= '0;
        else if (en)
            t7_reg <= td;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= fx_mul(sd[3*W-1:2*W], x2q);
            s_7_reg   <= sd[5*W-1:4*W];
            x3_7_reg  <= sd[4*W-1:3*W];
            x2_7_reg  <= x2q;
            b1_7_reg  <= sd[2*W-1:W];
            a11_7_reg <= sd[W-1:0];
        end
    end

    lus_tag_t t8_reg, t9_reg;
    word_t z_reg, s_8_reg, x3_8_reg, x2_8_reg, a11_8_reg;
    word_t z2_reg, x3_9_reg, x2_9_reg, a11_9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t8_reg <= '0;
            t9_reg <= '0;
        end
        else if (en)
        begin
            t8_reg <= t7_reg;
            t9_reg <= t8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg     <= fx_sub(b1_7_reg, w_reg);
            s_8_reg   <= s_7_reg;
            x3_8_reg  <= x3_7_reg;
            x2_8_reg  <= x2_7_reg;
            a11_8_reg <= a11_7_reg;
            z2_reg    <= fx_sub(z_reg, s_8_reg);
            x3_9_reg  <= x3_8_reg;
            x2_9_reg  <= x2_8_reg;
            a11_9_reg <= a11_8_reg;
        end
    end

    // x1 = z2 / a11
    lus_tag_t te;
    word_t    x1q;
    logic [2*W-1:0] se;

    lus_div #(.W(W), .F(F), .SIDE_W(2*W)) u_div_x1 (
        .clk(clk), .rst_n(rst_n), .en(en), .tag_in(t9_reg),
        .num(z2_reg), .den(a11_9_reg),
        .side_in({x2_9_reg, x3_9_reg}),
        .tag_out(te), .quo(x1q), .side_out(se)
    );

    // output register; a zero pivot forces the solution to zero
    word_t x1_reg, x2_reg, x3_reg;
    logic  singular_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= te.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg       <= te.singular ? '0 : x1q;
            x2_reg       <= te.singular ? '0 : se[2*W-1:W];
            x3_reg       <= te.singular ? '0 : se[W-1:0];
            singular_reg <= te.singular;
        end
    end

    assign out_valid = out_valid_reg;
    assign x1        = x1_reg;
    assign x2        = x2_reg;
    assign x3        = x3_reg;
    assign singular  = singular_reg;

endmodule

FILE: src/lus_div.sv
module lus_div #(
    parameter int W      = 32,
    parameter int F      = 16,
    parameter int SIDE_W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  lus_pkg::lus_tag_t     tag_in,
    input  logic signed [W-1:0]   num,
    input  logic signed [W-1:0]   den,
    input  logic [SIDE_W-1:0]     side_in,
    output lus_pkg::lus_tag_t     tag_out,
    output logic signed [W-1:0]   quo,
    output logic [SIDE_W-1:0]     side_out
);
    import lus_pkg::*;

    // restoring divider, one quotient bit per stage on (|num| << F) / |den|
    localparam int NW = W + F;

    logic [NW-1:0]     n_reg    [0:NW];
    logic [W:0]        r_reg    [0:NW];
    logic [NW-1:0]     q_reg    [0:NW];
    logic [W-1:0]      m_reg    [0:NW];
    logic              neg_reg  [0:NW];
    logic [SIDE_W-1:0] side_reg [0:NW];
    lus_tag_t          tag_reg  [0:NW];

    logic [W:0]        r_next   [0:NW-1];
    logic [NW-1:0]     q_next   [0:NW-1];

    lus_tag_t          tag_out_reg;
    logic signed [W-1:0] quo_reg;
    logic [SIDE_W-1:0] side_out_reg;

    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] lim;
    logic [W-1:0] qsat;

    assign num_mag = num[W-1] ? (~num + W'(1)) : num;
    assign den_mag = den[W-1] ? (~den + W'(1)) : den;

    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            logic [W:0] r_sh;
            logic       ge;
            r_sh = {r_reg[k][W-1:0], n_reg[k][NW-1]};
            ge = (r_sh >= {1'b0, m_reg[k]});
            r_next[k] = ge ? (r_sh - {1'b0, m_reg[k]}) : r_sh;
            q_next[k] = {q_reg[k][NW-2:0], ge};
        end
    end

    assign lim  = {1'b0, {(W-1){1'b1}}} + W'(neg_reg[NW]);
    assign qsat = (q_reg[NW] > {{F{1'b0}}, lim}) ? lim : q_reg[NW][W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
            begin
                tag_reg[k] <= '0;
            end
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int k = 0; k < NW; k++)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
            tag_out_reg <= tag_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= {num_mag, {F{1'b0}}};
            r_reg[0]    <= '0;
            q_reg[0]    <= '0;
            m_reg[0]    <= den_mag;
            neg_reg[0]  <= num[W-1] ^ den[W-1];
            side_reg[0] <= side_in;
            for (int k = 0; k < NW; k++)
            begin
                n_reg[k+1]    <= n_reg[k] << 1;
                r_reg[k+1]    <= r_next[k];
                q_reg[k+1]    <= q_next[k];
                m_reg[k+1]    <= m_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            quo_reg      <= neg_reg[NW] ? (~qsat + W'(1)) : qsat;
            side_out_reg <= side_reg[NW];
        end
    end

    assign tag_out  = tag_out_reg;
    assign quo      = quo_reg;
    assign side_out = side_out_reg;

endmodule

FILE: verif/lu_solve_checker.sv
module lu_solve_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] a11,
    input  logic signed [31:0] a12,
    input  logic signed [31:0] a13,
    input  logic signed [31:0] a21,
    input  logic signed [31:0] a22,
    input  logic signed [31:0] a23,
    input  logic signed [31:0] a31,
    input  logic signed [31:0] a32,
    input  logic signed [31:0] a33,
    input  logic signed [31:0] b1,
    input  logic signed [31:0] b2,
    input  logic signed [31:0] b3,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] x1,
    input  logic signed [31:0] x2,
    input  logic signed [31:0] x3,
    input  logic               singular,
    output int                 errors,
    output int                 pending
);

    localparam int FRAC = 16;
    localparam longint QMAX = 64'sd2147483647;

    typedef struct {
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic signed [31:0] x3;
        logic               singular;
    } solution_t;

    solution_t solutions_due[$];

    function automatic longint clamp_mag(longint mag, bit neg);
        longint lim;
        lim = neg ? QMAX + 1 : QMAX;
        if (mag > lim || mag < 0)
            mag = lim;
        return neg ? -mag : mag;
    endfunction

    function automatic longint q_sub(longint a, longint b);
        longint d;
        d = a - b;
        if (d > QMAX) return QMAX;
        if (d < -QMAX - 1) return -QMAX - 1;
        return d;
    endfunction

    // truncation toward zero on the magnitude
    function automatic longint q_mul(longint a, longint b);
        longint ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        return clamp_mag((ma * mb) >>> FRAC, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_div(longint a, longint d);
        longint ma, md;
        ma = a < 0 ? -a : a;
        md = d < 0 ? -d : d;
        if (md == 0) return 0;
        return clamp_mag((ma << FRAC) / md, (a < 0) != (d < 0));
    endfunction

    function automatic solution_t solve_system(longint m11, longint m12, longint m13,
                                               longint m21, longint m22, longint m23,
                                               longint m31, longint m32, longint m33,
                                               longint r1, longint r2, longint r3);
        solution_t s;
        longint l21, l31, l32, u22, u23, u33, y2, y3, s1, s2, s3;
        s.x1 = '0;
        s.x2 = '0;
        s.x3 = '0;
        s.singular = 1'b1;
        if (m11 == 0) return s;
        l21 = q_div(m21, m11);
        l31 = q_div(m31, m11);
        u22 = q_sub(m22, q_mul(l21, m12));
        u23 = q_sub(m23, q_mul(l21, m13));
        if (u22 == 0) return s;
        l32 = q_div(q_sub(m32, q_mul(l31, m12)), u22);
        u33 = q_sub(q_sub(m33, q_mul(l31, m13)), q_mul(l32, u23));
        if (u33 == 0) return s;
        y2 = q_sub(r2, q_mul(l21, r1));
        y3 = q_sub(q_sub(r3, q_mul(l31, r1)), q_mul(l32, y2));
        s3 = q_div(y3, u33);
        s2 = q_div(q_sub(y2, q_mul(u23, s3)), u22);
        s1 = q_div(q_sub(q_sub(r1, q_mul(m12, s2)), q_mul(m13, s3)), m11);
        s.x1 = s1[31:0];
        s.x2 = s2[31:0];
        s.x3 = s3[31:0];
        s.singular = 1'b0;
        return s;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (solutions_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = solutions_due.pop_front();
                    if (singular !== want.singular)
                    begin
                        $error("singular: expected %0d actual %0d", want.singular, singular);
                        errors++;
                    end
                    if (x1 !== want.x1)
                    begin
                        $error("x1: expected %0d actual %0d", want.x1, x1);
                        errors++;
                    end
                    if (x2 !== want.x2)
                    begin
                        $error("x2: expected %0d actual %0d", want.x2, x2);
                        errors++;
                    end
                    if (x3 !== want.x3)
                    begin
                        $error("x3: expected %0d actual %0d", want.x3, x3);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                solutions_due.push_back(solve_system(a11, a12, a13, a21, a22, a23,
                                                     a31, a32, a33, b1, b2, b3));
            pending = solutions_due.size();
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;

    localparam int ONE = 32'sh0001_0000;
    localparam int QMIN = 32'sh8000_0000;
    localparam int QMAX = 32'sh7fff_ffff;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] x1, x2, x3;
    logic               singular;
    int                 errors;
    int                 pending;
    int                 tx_pct;
    int                 rx_pct;
    bit                 hold_armed;

    lu_solve_3x3 u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a11(a11), .a12(a12), .a13(a13), .a21(a21), .a22(a22), .a23(a23),
        .a31(a31), .a32(a32), .a33(a33), .b1(b1), .b2(b2), .b3(b3),
        .out_valid(out_valid), .out_stall(out_stall),
        .x1(x1), .x2(x2), .x3(x3), .singular(singular)
    );

    lu_solve_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a11(a11), .a12(a12), .a13(a13), .a21(a21), .a22(a22), .a23(a23),
        .a31(a31), .a32(a32), .a33(a33), .b1(b1), .b2(b2), .b3(b3),
        .out_valid(out_valid), .out_stall(out_stall),
        .x1(x1), .x2(x2), .x3(x3), .singular(singular),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver; the long hold-off fills the pipe so in_stall rises
    initial
    begin
        int hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && hold_left == 0)
            begin
                hold_armed = 1'b0;
                hold_left = 700;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    task automatic send_system(input logic signed [31:0] m[12]);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        {a11, a12, a13, a21, a22, a23} <= {m[0], m[1], m[2], m[3], m[4], m[5]};
        {a31, a32, a33, b1, b2, b3} <= {m[6], m[7], m[8], m[9], m[10], m[11]};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] small_q();
        return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endfunction

    task automatic random_system();
        logic signed [31:0] m[12];
        int kind;
        kind = $urandom_range(99);
        foreach (m[i])
        begin
            if (kind < 60)
                m[i] = small_q();
            else if (kind < 85)
                m[i] = $urandom;
            else
                m[i] = $signed($urandom_range(0, 4)) - 2;
        end
        // diagonally dominant systems reach the full solve path
        if (kind < 40)
        begin
            m[0] = m[0] + 16 * ONE;
            m[4] = m[4] + 16 * ONE;
            m[8] = m[8] + 16 * ONE;
        end
        else if (kind < 48)
        begin
            // second row copies the first: U22 becomes zero
            m[3] = m[0];
            m[4] = m[1];
            m[5] = m[2];
        end
        else if (kind < 54)
            m[0] = 0;
        send_system(m);
    endtask

    initial
    begin
        logic signed [31:0] m[12];
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a11, a12, a13, a21, a22, a23, a31, a32, a33, b1, b2, b3} = '0;
        tx_pct = 0;
        rx_pct = 0;
        hold_armed = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 3 * ONE, -5 * ONE, 7};
        send_system(m);
        m = '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE, ONE, 2 * ONE, 3 * ONE};
        send_system(m);
        m = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE, ONE, ONE, ONE};
        send_system(m);
        m = '{ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, ONE};
        send_system(m);
        // third row is the sum of the first two: U33 is zero
        m = '{ONE, 0, ONE, 0, ONE, ONE, ONE, ONE, 2 * ONE, ONE, ONE, ONE};
        send_system(m);
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1, QMAX, QMIN, QMAX};
        send_system(m);
        m = '{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX};
        send_system(m);
        m = '{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN};
        send_system(m);
        m = '{QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, QMIN};
        send_system(m);
        m = '{-1, QMAX, QMIN, QMAX, 1, -1, QMIN, -1, 1, -1, -1, -1};
        send_system(m);
        m = '{-ONE, 0, 0, 2 * ONE, -ONE, 0, 3, 4, -ONE, QMIN, 0, -1};
        send_system(m);

        tx_pct = 36;
        rx_pct = 48;
        repeat (400) random_system();
        tx_pct = 48;
        rx_pct = 36;
        repeat (400) random_system();
        tx_pct = 0;
        rx_pct = 0;
        hold_armed = 1'b1;
        repeat (400) random_system();
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
